// File: rtl/assert_macros.svh
// Assertion helper macros for the deframer RTL.
// Included by every module that carries concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, clocked on clk, off while rst_n is low.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check, clocked on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sld_pkg.sv
// Shared types and constants for the sync/length packet deframer.
// No dependencies; used by sld_parser and sync_length_packet_deframer.
`default_nettype none

package sld_pkg;

    localparam int unsigned CFG_WIDTH = 16;

    localparam logic [7:0] SYNC_BYTE    = 8'h23;
    localparam logic [7:0] HEADER_BYTES = 8'd6;

    // register indexes, byte address is index * 4
    localparam logic REG_FRAME_LIMIT  = 1'b0;
    localparam logic REG_ACCEPT_LIMIT = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_SKIPPED  = 2'd1;
    localparam logic [1:0] KIND_FRAMING  = 2'd2;

    // positions inside a header burst
    localparam logic [2:0] BURST_LEN_LO_POS = 3'd4;
    localparam logic [2:0] BURST_LAST_POS   = 3'd5;

    // One emission of the parser: either a single word or a six-word header burst.
    typedef struct packed {
        logic       burst;   // expand into four sync bytes, low length, high length
        logic [1:0] kind;
        logic       last;    // single: last flag; burst: last flag of the sixth word
        logic [7:0] data;    // single: byte; burst: high length byte
        logic [7:0] len_lo;  // burst only: low length byte
    } desc_t;

endpackage

`default_nettype wire

// File: rtl/sld_parser.sv
// Header hunt, length check and body tracking of the deframer.
// Depends on sld_pkg and assert_macros.svh; one byte in, at most one descriptor out.
`default_nettype none

module sld_parser #(
    parameter int LENGTH_WIDTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire logic [7:0]                      in_byte,
    input  wire logic [sld_pkg::CFG_WIDTH-1:0]   frame_limit,
    input  wire logic [sld_pkg::CFG_WIDTH-1:0]   accept_limit,
    output sld_pkg::desc_t                       desc,
    output logic                                 emit
);
    import sld_pkg::*;

    `include "assert_macros.svh"

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;

    localparam logic [2:0] HPOS_LEN_LO = 3'd4;
    localparam logic [2:0] HPOS_LEN_HI = 3'd5;

    logic [1:0]              phase_reg,  phase_next;
    logic [2:0]              hpos_reg,   hpos_next;
    logic [7:0]              len_lo_reg, len_lo_next;
    logic [LENGTH_WIDTH-1:0] remain_reg, remain_next;

    logic [15:0]             len_full;
    logic [LENGTH_WIDTH-1:0] len_w;
    logic [CFG_WIDTH-1:0]    len_ext;
    logic [LENGTH_WIDTH-1:0] body_len;
    logic [LENGTH_WIDTH-1:0] remain_dec;
    logic [2:0]              hpos_eff;
    logic                    in_body;

    assign len_full   = {in_byte, len_lo_reg};
    assign len_w      = len_full[LENGTH_WIDTH-1:0];
    assign len_ext    = CFG_WIDTH'(len_w);
    assign body_len   = len_w - LENGTH_WIDTH'(HEADER_BYTES);
    assign remain_dec = remain_reg - LENGTH_WIDTH'(1);
    assign in_body    = (phase_reg == PH_BODY) || (phase_reg == PH_SKIP);

    always_comb
    begin
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        len_lo_next = len_lo_reg;
        remain_next = remain_reg;
        emit        = 1'b0;
        desc        = '0;
        hpos_eff    = hpos_reg;

        if (in_body && (remain_reg != '0))
        begin
            // count one body byte, pass it on when delivering
            remain_next = remain_dec;
            if (remain_dec == '0)
            begin
                phase_next = PH_HUNT;
                hpos_next  = '0;
            end
            if (phase_reg == PH_BODY)
            begin
                emit        = 1'b1;
                desc.kind   = KIND_BYTE;
                desc.data   = in_byte;
                desc.last   = (remain_dec == '0);
            end
        end
        else
        begin
            if ((phase_reg != PH_HUNT) || (hpos_reg > HPOS_LEN_HI))
            begin
                phase_next  = PH_HUNT;
                hpos_eff    = '0;
                remain_next = '0;
            end

            if (hpos_eff < HPOS_LEN_LO)
            begin
                hpos_next = (in_byte == SYNC_BYTE) ? hpos_eff + 3'd1 : 3'd0;
            end
            else if (hpos_eff == HPOS_LEN_LO)
            begin
                len_lo_next = in_byte;
                hpos_next   = HPOS_LEN_HI;
            end
            else
            begin
                hpos_next = '0;
                emit      = 1'b1;
                if ((len_ext < CFG_WIDTH'(HEADER_BYTES)) || (len_ext > frame_limit))
                begin
                    phase_next  = PH_HUNT;
                    remain_next = '0;
                    desc.kind   = KIND_FRAMING;
                end
                else if (len_ext > accept_limit)
                begin
                    remain_next = body_len;
                    phase_next  = (body_len == '0) ? PH_HUNT : PH_SKIP;
                    desc.kind   = KIND_SKIPPED;
                end
                else
                begin
                    remain_next = body_len;
                    phase_next  = (body_len == '0) ? PH_HUNT : PH_BODY;
                    desc.burst  = 1'b1;
                    desc.kind   = KIND_BYTE;
                    desc.data   = in_byte;
                    desc.len_lo = len_lo_reg;
                    desc.last   = (body_len == '0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            hpos_reg   <= '0;
            len_lo_reg <= '0;
            remain_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            len_lo_reg <= len_lo_next;
            remain_reg <= remain_next;
        end
    end

    `ASSERT_IMPLY(a_body_no_hpos, in_body, hpos_reg == 3'd0,
        "header position nonzero while in a packet body")
    `ASSERT_IMPLY(a_body_has_remain, in_body, remain_reg != '0,
        "packet body phase with no bytes remaining")
    `ASSERT_IMPLY(a_hpos_range, 1'b1, hpos_reg <= HPOS_LEN_HI,
        "header position beyond the length bytes")

endmodule

`default_nettype wire

// File: rtl/sync_length_packet_deframer.sv
// An accepted byte passes the input register, then the result register, on its way to
// m_tdata; a header within the accept limit turns its sixth byte into six output words.
// Throughput: one byte per cycle in a packet body unless m_tready is low; a header burst
// holds the result register for six words, the input register takes one more byte meanwhile.
// Reset: rst_n clears the hunt state and both stages; limits return to 2048.
// Depends on sld_pkg, sld_parser and assert_macros.svh.
`default_nettype none

module sync_length_packet_deframer #(
    parameter int LENGTH_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // byte stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte

    // packet stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,   // last
    output logic [1:0]       m_tuser,   // [1:0] kind

    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sld_pkg::*;

    `include "assert_macros.svh"

    localparam logic [CFG_WIDTH-1:0] LIMIT_RESET = 16'd2048;

    // ---------------------------------------------------------------
    // Configuration registers. Written only while the stream is idle
    // (user rule, not enforced), so the parser reads them directly.
    // ---------------------------------------------------------------
    logic [CFG_WIDTH-1:0] frame_limit_reg;
    logic [CFG_WIDTH-1:0] accept_limit_reg;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_limit_reg  <= LIMIT_RESET;
            accept_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FRAME_LIMIT:  frame_limit_reg  <= pwdata[CFG_WIDTH-1:0];
                REG_ACCEPT_LIMIT: accept_limit_reg <= pwdata[CFG_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAME_LIMIT:  prdata = 32'(frame_limit_reg);
            REG_ACCEPT_LIMIT: prdata = 32'(accept_limit_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input register: hold one byte until the parser can take it. It
    // frees up as soon as the result stage has room; while a result word
    // waits downstream, it takes at most one more byte from upstream.
    // ---------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Result stage: one descriptor, expanded into six words for an accepted header.
    logic       desc_valid_reg;
    desc_t      desc_reg;
    logic [2:0] pos_reg;

    desc_t      desc_next;
    logic       emit;
    logic       finish;
    logic       desc_free;
    logic       advance;
    logic       load;

    assign finish    = desc_valid_reg && m_tready &&
                       (!desc_reg.burst || (pos_reg == BURST_LAST_POS));
    assign desc_free = !desc_valid_reg || finish;
    assign advance   = in_valid_reg && desc_free;
    assign load      = advance && emit;
    assign s_tready  = !in_valid_reg || desc_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // ---------------------------------------------------------------
    // Parser: hunt for the sync header, check the length, track the
    // body. Advance its state only when the byte is consumed.
    // ---------------------------------------------------------------
    sld_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_byte      (in_byte_reg),
        .frame_limit  (frame_limit_reg),
        .accept_limit (accept_limit_reg),
        .desc         (desc_next),
        .emit         (emit)
    );

    // ---------------------------------------------------------------
    // Result stage. A descriptor is replaced in the same cycle its last
    // word leaves, so body bytes stream at one per cycle while m_tready is high.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            if (load)
            begin
                desc_valid_reg <= 1'b1;
            end
            else if (finish)
            begin
                desc_valid_reg <= 1'b0;
            end

            if (load || finish)
            begin
                pos_reg <= '0;
            end
            else if (desc_valid_reg && m_tready && desc_reg.burst)
            begin
                pos_reg <= pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= desc_next;
        end
    end

    // Expand a header burst: four sync bytes, low length, high length.
    always_comb
    begin
        m_tvalid = desc_valid_reg;
        m_tuser  = desc_reg.kind;
        m_tlast  = 1'b0;
        m_tdata  = desc_reg.data;
        if (desc_reg.burst)
        begin
            if (pos_reg < BURST_LEN_LO_POS)
            begin
                m_tdata = SYNC_BYTE;
            end
            else if (pos_reg == BURST_LEN_LO_POS)
            begin
                m_tdata = desc_reg.len_lo;
            end
            else
            begin
                m_tlast = desc_reg.last;
            end
        end
        else
        begin
            m_tlast = desc_reg.last;
        end
    end

    `ASSERT_IMPLY(a_pos_in_burst, pos_reg != 3'd0, desc_valid_reg && desc_reg.burst,
        "burst position set without a pending header burst")
    `ASSERT_IMPLY(a_pos_range, 1'b1, pos_reg <= BURST_LAST_POS,
        "burst position beyond the sixth header word")
    `ASSERT_IMPLY(a_last_is_byte, m_tvalid && m_tlast, m_tuser == KIND_BYTE,
        "last flag on an event report")
    `ASSERT_NEXT(a_in_hold, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg),
        "input byte lost or changed while the parser is stalled")

endmodule

`default_nettype wire
